### sv/rsk_pkg.sv
// rsk_pkg: shared types, constants and step helpers of the relay step keypad controller
// no dependencies; used by rsk_step, relay_step_keypad_controller and the bench
package rsk_pkg;

    // outcome of one step of a relay count
    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_STEP  = 2'd1,
        RES_LIMIT = 2'd2
    } t_res;

    // configuration register indexes
    localparam logic [1:0] CFG_CAP_MAX = 2'd0;
    localparam logic [1:0] CFG_CAP_MIN = 2'd1;
    localparam logic [1:0] CFG_IND_MAX = 2'd2;
    localparam logic [1:0] CFG_IND_MIN = 2'd3;

    // repeat timing of held buttons
    localparam logic [7:0] DELAY_SLOW = 8'd200;
    localparam logic [7:0] DELAY_MID  = 8'd100;
    localparam logic [7:0] DELAY_FAST = 8'd75;
    localparam logic [7:0] TRIG_MID   = 8'd8;
    localparam logic [7:0] TRIG_FAST  = 8'd32;

    localparam logic [7:0] BAR_ALL_ON = 8'hff;

    // button levels of one tick
    typedef struct packed {
        logic cap_up;
        logic cap_down;
        logic ind_up;
        logic ind_down;
        logic other_button;
        logic rf_absent;
        logic power_on;
    } t_keys;

    // count limits from the register file
    typedef struct packed {
        logic [7:0] cap_max;
        logic [7:0] cap_min;
        logic [7:0] ind_max;
        logic [7:0] ind_min;
    } t_limits;

    // controller state carried from tick to tick
    typedef struct packed {
        logic       session_on;
        logic [7:0] since_trigger;
        logic [7:0] repeat_delay;
        logic [7:0] trigger_count;
        logic [8:0] since_button;
        logic [6:0] since_blink;
        logic [7:0] cap_count;
        logic [7:0] ind_count;
        t_res       cap_result;
        t_res       ind_result;
        logic [7:0] blink_pattern;
        logic       upper_blinking;
        logic       lower_blinking;
        logic [2:0] upper_blinks;
        logic [2:0] lower_blinks;
    } t_state;

    // result of one tick
    typedef struct packed {
        logic       active;
        logic [7:0] upper_bar;
        logic [7:0] lower_bar;
        logic       draw_frame;
        logic       clear_display;
        logic       relays_write;
        logic [7:0] cap_value;
        logic [7:0] ind_value;
    } t_frame;

    // new count and outcome of one step
    typedef struct packed {
        logic [7:0] count;
        t_res       res;
    } t_step;

    // step a count up or down inside its limits, never wrapping
    function automatic t_step step_count(input logic [7:0] cnt, input logic up,
                                         input logic down, input logic [7:0] hi,
                                         input logic [7:0] lo);
        t_step r;
        r.count = cnt;
        r.res   = RES_NONE;
        if (up && down) begin
            r.res = RES_NONE;
        end else if (up) begin
            if (cnt < hi) begin
                r.count = cnt + 8'd1;
                r.res   = RES_STEP;
            end else begin
                r.res = RES_LIMIT;
            end
        end else if (down) begin
            if (cnt > lo) begin
                r.count = cnt - 8'd1;
                r.res   = RES_STEP;
            end else begin
                r.res = RES_LIMIT;
            end
        end
        return r;
    endfunction

    // repeat interval after a number of steps
    function automatic logic [7:0] delay_for(input logic [7:0] n);
        logic [7:0] d;
        if (n < TRIG_MID) begin
            d = DELAY_SLOW;
        end else if (n < TRIG_FAST) begin
            d = DELAY_MID;
        end else begin
            d = DELAY_FAST;
        end
        return d;
    endfunction

endpackage

### sv/relay_step_keypad_controller.sv
// relay_step_keypad_controller: top level with beat registers, limit registers and state
// depends on rsk_pkg and rsk_step
// a beat goes from the input register to the result register once the output side is free
// throughput: one beat per cycle unless the output stalls, each update one pass of rsk_step
// the registers decouple the two sides, so one more beat is taken while a result waits
// reset: synchronous, active low; clears session state, counts and valid flags,
// limits return to max 255 and min 0, the blink pattern to all ones
module relay_step_keypad_controller #(
    parameter int LINGER_TICKS  = 500,
    parameter int BLINK_TICKS   = 100,
    parameter int BLINK_TOGGLES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cap_up, cap_down, ind_up, ind_down, other_button, rf_absent, power_on, 0
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // active, upper_bar[8], lower_bar[8], draw_frame, clear_display,
    // relays_write, cap_value[8], ind_value[8], zero fill[4]
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    logic             r_in_valid;
    rsk_pkg::t_keys   r_in_keys;
    logic             r_out_valid;
    rsk_pkg::t_frame  r_out_frame;
    rsk_pkg::t_state  r_state;
    rsk_pkg::t_limits r_limits;
    rsk_pkg::t_state  n_state;
    rsk_pkg::t_frame  n_frame;
    rsk_pkg::t_keys   w_keys;
    rsk_pkg::t_state  w_rst_state;
    logic             w_in_fire;
    logic             w_work;

    // unpack the input beat
    assign w_keys.cap_up       = i_s_axis_tdata[0];
    assign w_keys.cap_down     = i_s_axis_tdata[1];
    assign w_keys.ind_up       = i_s_axis_tdata[2];
    assign w_keys.ind_down     = i_s_axis_tdata[3];
    assign w_keys.other_button = i_s_axis_tdata[4];
    assign w_keys.rf_absent    = i_s_axis_tdata[5];
    assign w_keys.power_on     = i_s_axis_tdata[6];

    // handshake of the two register stages
    assign w_work          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_work;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_work) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_keys <= w_keys;
        end
    end

    // per-tick update
    rsk_step #(
        .LINGER_TICKS  (LINGER_TICKS),
        .BLINK_TICKS   (BLINK_TICKS),
        .BLINK_TOGGLES (BLINK_TOGGLES)
    ) u_step (
        .i_keys   (r_in_keys),
        .i_limits (r_limits),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_frame  (n_frame)
    );

    // reset value of the controller state
    always_comb begin
        w_rst_state               = '0;
        w_rst_state.cap_result    = rsk_pkg::RES_NONE;
        w_rst_state.ind_result    = rsk_pkg::RES_NONE;
        w_rst_state.blink_pattern = rsk_pkg::BAR_ALL_ON;
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= w_rst_state;
        end else if (w_work) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_work) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_work) begin
            r_out_frame <= n_frame;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.cap_max <= 8'hff;
            r_limits.cap_min <= 8'h00;
            r_limits.ind_max <= 8'hff;
            r_limits.ind_min <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rsk_pkg::CFG_CAP_MAX: r_limits.cap_max <= i_cfg_data;
                rsk_pkg::CFG_CAP_MIN: r_limits.cap_min <= i_cfg_data;
                rsk_pkg::CFG_IND_MAX: r_limits.ind_max <= i_cfg_data;
                rsk_pkg::CFG_IND_MIN: r_limits.ind_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pack the result beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000,
                              r_out_frame.ind_value,
                              r_out_frame.cap_value,
                              r_out_frame.relays_write,
                              r_out_frame.clear_display,
                              r_out_frame.draw_frame,
                              r_out_frame.lower_bar,
                              r_out_frame.upper_bar,
                              r_out_frame.active};

`ifndef SYNTHESIS
    // state moves only when a beat is worked
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_work |=> $stable(r_state))
        else $error("state changed without a beat");

    // a relay write always comes with a changed count
    a_write_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work && n_frame.relays_write |=>
            (r_state.cap_count != $past(r_state.cap_count)) ||
            (r_state.ind_count != $past(r_state.ind_count)))
        else $error("relay write without a count change");

    // a clear pulse closes the session
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work && n_frame.clear_display |=> !r_state.session_on && !r_out_frame.active)
        else $error("session still running after clear");

    // a worked beat is presented on the result side
    a_work_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work |=> o_m_axis_tvalid)
        else $error("worked beat not presented");
`endif

endmodule

### sv/rsk_step.sv
// rsk_step: per-tick update of the keypad session, stepping and bar blinking
// depends on rsk_pkg; purely combinational, registered by the top level
module rsk_step #(
    parameter int LINGER_TICKS  = 500,
    parameter int BLINK_TICKS   = 100,
    parameter int BLINK_TOGGLES = 6
) (
    input  rsk_pkg::t_keys   i_keys,
    input  rsk_pkg::t_limits i_limits,
    input  rsk_pkg::t_state  i_state,
    output rsk_pkg::t_state  o_state,
    output rsk_pkg::t_frame  o_frame
);

    localparam logic [8:0] LINGER_LIM  = 9'(LINGER_TICKS);
    localparam logic [6:0] BLINK_LIM   = 7'(BLINK_TICKS);
    localparam logic [2:0] TOGGLE_LIM  = 3'(BLINK_TOGGLES);

    rsk_pkg::t_state w_s;
    rsk_pkg::t_frame w_f;
    rsk_pkg::t_step  w_cap;
    rsk_pkg::t_step  w_ind;
    logic            w_relay;
    logic            w_end;
    logic [7:0]      w_fu;
    logic [7:0]      w_fl;

    // one tick of the session
    always_comb begin
        w_s     = i_state;
        w_f     = '0;
        w_end   = 1'b0;
        w_fu    = '0;
        w_fl    = '0;
        w_relay = i_keys.cap_up | i_keys.cap_down | i_keys.ind_up | i_keys.ind_down;
        w_cap   = rsk_pkg::step_count(w_s.cap_count, i_keys.cap_up, i_keys.cap_down,
                                      i_limits.cap_max, i_limits.cap_min);
        w_ind   = rsk_pkg::step_count(w_s.ind_count, i_keys.ind_up, i_keys.ind_down,
                                      i_limits.ind_max, i_limits.ind_min);

        // session start on a relay button with power on
        if (!w_s.session_on && i_keys.power_on && w_relay) begin
            w_s.session_on    = 1'b1;
            w_s.since_trigger = '0;
            w_s.repeat_delay  = '0;
            w_s.trigger_count = '0;
            w_s.cap_result    = rsk_pkg::RES_NONE;
            w_s.ind_result    = rsk_pkg::RES_NONE;
            w_s.since_button  = '0;
        end

        if (w_s.session_on) begin
            // end on idle timeout or a foreign button
            if (w_relay) begin
                w_s.since_button = '0;
            end else if (i_keys.other_button) begin
                w_end = 1'b1;
            end
            if (w_s.since_button >= LINGER_LIM) begin
                w_end = 1'b1;
            end

            if (w_end) begin
                w_s.session_on  = 1'b0;
                w_f.clear_display = 1'b1;
            end else begin
                // repeat stepping
                if (w_s.since_trigger >= w_s.repeat_delay) begin
                    w_s.since_trigger = '0;
                    w_s.cap_count     = w_cap.count;
                    w_s.cap_result    = w_cap.res;
                    w_s.ind_count     = w_ind.count;
                    w_s.ind_result    = w_ind.res;
                    w_f.relays_write  = (w_cap.res == rsk_pkg::RES_STEP) ||
                                        (w_ind.res == rsk_pkg::RES_STEP);
                    if (w_s.trigger_count != 8'hff) begin
                        w_s.trigger_count = w_s.trigger_count + 8'd1;
                    end
                    w_s.repeat_delay = rsk_pkg::delay_for(w_s.trigger_count);
                end

                // blink start at a limit
                if (!w_s.upper_blinking && !w_s.lower_blinking &&
                    (w_s.cap_result == rsk_pkg::RES_LIMIT ||
                     w_s.ind_result == rsk_pkg::RES_LIMIT)) begin
                    w_s.since_blink   = '0;
                    w_s.blink_pattern = rsk_pkg::BAR_ALL_ON;
                end
                if (w_s.cap_result == rsk_pkg::RES_STEP) begin
                    w_s.lower_blinking = 1'b0;
                end else if (w_s.cap_result == rsk_pkg::RES_LIMIT) begin
                    w_s.lower_blinking = 1'b1;
                    w_s.lower_blinks   = '0;
                end
                if (w_s.ind_result == rsk_pkg::RES_STEP) begin
                    w_s.upper_blinking = 1'b0;
                end else if (w_s.ind_result == rsk_pkg::RES_LIMIT) begin
                    w_s.upper_blinking = 1'b1;
                    w_s.upper_blinks   = '0;
                end

                // bar frames and blink toggling
                w_fu = w_s.ind_count;
                w_fl = w_s.cap_count;
                if (w_s.upper_blinking || w_s.lower_blinking) begin
                    if (w_s.upper_blinking) begin
                        w_fu = w_s.blink_pattern;
                    end
                    if (w_s.lower_blinking) begin
                        w_fl = w_s.blink_pattern;
                    end
                    if (w_s.since_blink >= BLINK_LIM) begin
                        w_s.since_blink = '0;
                        if (w_s.upper_blinking) begin
                            w_s.upper_blinks = w_s.upper_blinks + 3'd1;
                        end
                        if (w_s.upper_blinks == TOGGLE_LIM) begin
                            w_s.upper_blinking = 1'b0;
                        end
                        if (w_s.lower_blinking) begin
                            w_s.lower_blinks = w_s.lower_blinks + 3'd1;
                        end
                        if (w_s.lower_blinks == TOGGLE_LIM) begin
                            w_s.lower_blinking = 1'b0;
                        end
                        w_s.blink_pattern = ~w_s.blink_pattern;
                    end
                end

                w_f.active     = 1'b1;
                w_f.upper_bar  = w_fu;
                w_f.lower_bar  = w_fl;
                w_f.draw_frame = i_keys.rf_absent;

                // saturating session timers
                if (w_s.since_trigger != 8'hff) begin
                    w_s.since_trigger = w_s.since_trigger + 8'd1;
                end
                if (w_s.since_button != 9'h1ff) begin
                    w_s.since_button = w_s.since_button + 9'd1;
                end
            end
        end

        // blink timer runs on every tick
        if (w_s.since_blink != 7'h7f) begin
            w_s.since_blink = w_s.since_blink + 7'd1;
        end

        w_f.cap_value = w_s.cap_count;
        w_f.ind_value = w_s.ind_count;
    end

    assign o_state = w_s;
    assign o_frame = w_f;

endmodule

### bench/tb_relay_step_keypad_controller.sv
// tb_relay_step_keypad_controller: self-checking bench for the relay step keypad controller
// drives tick beats and limit writes, predicts every result frame, compares field by field
// depends on rsk_pkg and relay_step_keypad_controller
`timescale 1ns / 1ps

module tb_relay_step_keypad_controller;

    localparam int LINGER_TICKS  = 500;
    localparam int BLINK_TICKS   = 100;
    localparam int BLINK_TOGGLES = 6;

    // repeat timing of held buttons
    localparam logic [7:0] GAP_SLOW  = 8'd200;
    localparam logic [7:0] GAP_MID   = 8'd100;
    localparam logic [7:0] GAP_FAST  = 8'd75;
    localparam logic [7:0] STEPS_MID  = 8'd8;
    localparam logic [7:0] STEPS_FAST = 8'd32;

    // relay button masks, bit order of the beat
    localparam logic [3:0] RLY_NONE     = 4'b0000;
    localparam logic [3:0] RLY_CAP_UP   = 4'b0001;
    localparam logic [3:0] RLY_CAP_DOWN = 4'b0010;
    localparam logic [3:0] RLY_IND_UP   = 4'b0100;
    localparam logic [3:0] RLY_IND_DOWN = 4'b1000;
    localparam logic [3:0] RLY_ALL      = 4'b1111;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_valid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_data = '0;

    relay_step_keypad_controller #(
        .LINGER_TICKS  (LINGER_TICKS),
        .BLINK_TICKS   (BLINK_TICKS),
        .BLINK_TOGGLES (BLINK_TOGGLES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // pending tick beats and expected frames
    logic [7:0]      tick_q[$];
    rsk_pkg::t_frame frame_q[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left = 0;
    bit beat_taken = 0;
    int ticks_queued = 0;
    int ticks_taken = 0;
    int mismatches = 0;
    int n_ends = 0;
    int n_writes = 0;
    int n_blink = 0;
    int peak_steps = 0;

    // mirror of the limit registers
    logic [7:0] cap_hi = 8'd255;
    logic [7:0] cap_lo = 8'd0;
    logic [7:0] ind_hi = 8'd255;
    logic [7:0] ind_lo = 8'd0;

    // mirror of the controller state, at reset values
    logic          sess = 1'b0;
    logic [7:0]    trig_age = '0;
    logic [7:0]    rep_gap = '0;
    logic [7:0]    trig_n = '0;
    logic [8:0]    idle_age = '0;
    logic [6:0]    blink_age = '0;
    logic [7:0]    cap_n = '0;
    logic [7:0]    ind_n = '0;
    rsk_pkg::t_res cap_out = rsk_pkg::RES_NONE;
    rsk_pkg::t_res ind_out = rsk_pkg::RES_NONE;
    logic [7:0]    blink_bits = 8'hff;
    logic          up_blink = 1'b0;
    logic          lo_blink = 1'b0;
    logic [2:0]    up_toggles = '0;
    logic [2:0]    lo_toggles = '0;

    // beat layout: relay buttons in bits 3:0, then other, rf_absent, power_on
    function automatic logic [7:0] panel_keys(input logic [3:0] relay, input logic oth,
                                              input logic rf, input logic pwr);
        return {1'b0, pwr, rf, oth, relay};
    endfunction

    // one step of a relay count against its limits, no wrap
    task automatic bump_relay(inout logic [7:0] cnt, input logic up, input logic down,
                              input logic [7:0] hi, input logic [7:0] lo,
                              output rsk_pkg::t_res res);
        res = rsk_pkg::RES_NONE;
        if (up && !down) begin
            if (cnt < hi) begin
                cnt = cnt + 8'd1;
                res = rsk_pkg::RES_STEP;
            end else begin
                res = rsk_pkg::RES_LIMIT;
            end
        end else if (down && !up) begin
            if (cnt > lo) begin
                cnt = cnt - 8'd1;
                res = rsk_pkg::RES_STEP;
            end else begin
                res = rsk_pkg::RES_LIMIT;
            end
        end
    endtask

    // advance the mirrored state by one tick and build the frame it yields
    task automatic advance_panel(input logic [7:0] beat, output rsk_pkg::t_frame f);
        logic       cu, cd, iu, id, oth, rf, pwr, any_relay, quit;
        logic [7:0] show_up, show_lo;
        cu  = beat[0];
        cd  = beat[1];
        iu  = beat[2];
        id  = beat[3];
        oth = beat[4];
        rf  = beat[5];
        pwr = beat[6];
        any_relay = cu | cd | iu | id;
        f = '0;

        // session start, the starting tick is processed right away
        if (!sess && pwr && any_relay) begin
            sess     = 1'b1;
            trig_age = '0;
            rep_gap  = '0;
            trig_n   = '0;
            cap_out  = rsk_pkg::RES_NONE;
            ind_out  = rsk_pkg::RES_NONE;
            idle_age = '0;
        end

        if (sess) begin
            quit = 1'b0;
            if (any_relay) begin
                idle_age = '0;
            end else if (oth) begin
                quit = 1'b1;
            end
            if (idle_age >= LINGER_TICKS) quit = 1'b1;

            if (quit) begin
                sess = 1'b0;
                f.clear_display = 1'b1;
            end else begin
                // stepping with acceleration
                if (trig_age >= rep_gap) begin
                    trig_age = '0;
                    bump_relay(cap_n, cu, cd, cap_hi, cap_lo, cap_out);
                    bump_relay(ind_n, iu, id, ind_hi, ind_lo, ind_out);
                    f.relays_write = (cap_out == rsk_pkg::RES_STEP) ||
                                     (ind_out == rsk_pkg::RES_STEP);
                    if (trig_n != 8'hff) trig_n = trig_n + 8'd1;
                    if (trig_n < STEPS_MID) begin
                        rep_gap = GAP_SLOW;
                    end else if (trig_n < STEPS_FAST) begin
                        rep_gap = GAP_MID;
                    end else begin
                        rep_gap = GAP_FAST;
                    end
                end

                // blink animation of bars at a limit
                if (!up_blink && !lo_blink &&
                    (cap_out == rsk_pkg::RES_LIMIT || ind_out == rsk_pkg::RES_LIMIT)) begin
                    blink_age  = '0;
                    blink_bits = 8'hff;
                end
                if (cap_out == rsk_pkg::RES_STEP) begin
                    lo_blink = 1'b0;
                end else if (cap_out == rsk_pkg::RES_LIMIT) begin
                    lo_blink   = 1'b1;
                    lo_toggles = '0;
                end
                if (ind_out == rsk_pkg::RES_STEP) begin
                    up_blink = 1'b0;
                end else if (ind_out == rsk_pkg::RES_LIMIT) begin
                    up_blink   = 1'b1;
                    up_toggles = '0;
                end

                show_up = ind_n;
                show_lo = cap_n;
                if (up_blink || lo_blink) begin
                    if (up_blink) show_up = blink_bits;
                    if (lo_blink) show_lo = blink_bits;
                    if (blink_age >= BLINK_TICKS) begin
                        blink_age = '0;
                        if (up_blink) up_toggles = up_toggles + 3'd1;
                        if (up_toggles == BLINK_TOGGLES) up_blink = 1'b0;
                        if (lo_blink) lo_toggles = lo_toggles + 3'd1;
                        if (lo_toggles == BLINK_TOGGLES) lo_blink = 1'b0;
                        blink_bits = ~blink_bits;
                    end
                end

                f.active     = 1'b1;
                f.upper_bar  = show_up;
                f.lower_bar  = show_lo;
                f.draw_frame = rf;
                if (trig_age != 8'hff) trig_age = trig_age + 8'd1;
                if (idle_age != 9'h1ff) idle_age = idle_age + 9'd1;
            end
        end

        if (blink_age != 7'h7f) blink_age = blink_age + 7'd1;
        f.cap_value = cap_n;
        f.ind_value = ind_n;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    task automatic add_tick(input logic [7:0] beat);
        tick_q.push_back(beat);
        ticks_queued++;
    endtask

    // one limit write per falling edge, then the write enable drops
    task automatic write_limits(input logic [7:0] cmax, input logic [7:0] cmin,
                                input logic [7:0] imax, input logic [7:0] imin);
        logic [7:0] vals[4];
        logic [1:0] regs[4];
        vals = '{cmax, cmin, imax, imin};
        regs = '{rsk_pkg::CFG_CAP_MAX, rsk_pkg::CFG_CAP_MIN,
                 rsk_pkg::CFG_IND_MAX, rsk_pkg::CFG_IND_MIN};
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_addr <= regs[k];
            cfg_data <= vals[k];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cap_hi = cmax;
        cap_lo = cmin;
        ind_hi = imax;
        ind_lo = imin;
    endtask

    // waits until every queued beat has been taken and its frame checked
    task automatic wait_drained();
        while (tick_q.size() != 0 || frame_q.size() != 0) @(posedge i_clk);
    endtask

    // random button sessions: start, hold, release, then end, resume or linger out
    task automatic queue_sessions(input int n_ticks);
        int         target, hold_len, gap, pick, burst;
        logic [3:0] relay;
        logic       first;
        target = ticks_queued + n_ticks;
        while (ticks_queued < target) begin
            // noise between sessions
            if ($urandom_range(99) < 15) begin
                burst = $urandom_range(1, 6);
                repeat (burst) add_tick(8'($urandom_range(0, 127)));
            end
            relay = 4'($urandom_range(1, 15));
            first = 1'b1;
            pick  = 80;
            while (pick >= 75 && pick < 90) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    hold_len = $urandom_range(1, 8);
                end else if (pick < 90) begin
                    hold_len = $urandom_range(9, 230);
                end else begin
                    hold_len = $urandom_range(231, 450);
                end
                repeat (hold_len) begin
                    if ($urandom_range(24) == 0) relay = 4'($urandom_range(1, 15));
                    add_tick(panel_keys(relay, 1'($urandom), 1'($urandom),
                                        first | 1'($urandom)));
                    first = 1'b0;
                end
                gap = $urandom_range(0, 30);
                repeat (gap) add_tick(panel_keys(RLY_NONE, 1'b0, 1'($urandom), 1'($urandom)));
                pick = $urandom_range(99);
            end
            if (pick < 75) begin
                add_tick(panel_keys(RLY_NONE, 1'b1, 1'($urandom), 1'($urandom)));
            end else begin
                repeat (LINGER_TICKS + 2) begin
                    add_tick(panel_keys(RLY_NONE, 1'b0, 1'($urandom), 1'($urandom)));
                end
            end
        end
    endtask

    // sender: new beat at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= tick_q[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
        beat_taken = 0;
    end

    // accepted tick beat: predict its frame
    always @(posedge i_clk) begin : accept
        rsk_pkg::t_frame f;
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            void'(tick_q.pop_front());
            beat_taken = 1;
            ticks_taken++;
            advance_panel(s_data, f);
            frame_q.push_back(f);
            if (f.clear_display) n_ends++;
            if (f.relays_write) n_writes++;
            if (f.active && (up_blink || lo_blink)) n_blink++;
            if (int'(trig_n) > peak_steps) peak_steps = int'(trig_n);
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // result beat: compare with the oldest expected frame
    always @(posedge i_clk) begin : monitor
        rsk_pkg::t_frame want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (frame_q.size() == 0) begin
                $error("result beat with no expected frame: %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = frame_q.pop_front();
                check_field("active", 8'(want.active), 8'(o_m_axis_tdata[0]));
                check_field("upper_bar", want.upper_bar, o_m_axis_tdata[8:1]);
                check_field("lower_bar", want.lower_bar, o_m_axis_tdata[16:9]);
                check_field("draw_frame", 8'(want.draw_frame), 8'(o_m_axis_tdata[17]));
                check_field("clear_display", 8'(want.clear_display),
                            8'(o_m_axis_tdata[18]));
                check_field("relays_write", 8'(want.relays_write),
                            8'(o_m_axis_tdata[19]));
                check_field("cap_value", want.cap_value, o_m_axis_tdata[27:20]);
                check_field("ind_value", want.ind_value, o_m_axis_tdata[35:28]);
            end
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int mark;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 29;
        rcv_idle_pct = 84;
        write_limits(8'd255, 8'd0, 8'd255, 8'd0);

        // directed ticks
        add_tick(panel_keys(RLY_NONE, 1'b0, 1'b0, 1'b0));
        add_tick(panel_keys(RLY_CAP_UP, 1'b0, 1'b1, 1'b0));          // no power, no session
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));            // other alone, no session
        add_tick(panel_keys(RLY_CAP_DOWN, 1'b0, 1'b1, 1'b1));        // down at zero, limit
        add_tick(panel_keys(RLY_CAP_DOWN, 1'b0, 1'b0, 1'b0));        // power drop ignored
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));            // end by other button
        add_tick(panel_keys(RLY_CAP_UP | RLY_CAP_DOWN | RLY_IND_UP, 1'b0, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_ALL, 1'b1, 1'b1, 1'b1));             // both ways on both
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b0, 1'b0));
        add_tick(panel_keys(RLY_IND_DOWN, 1'b0, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_IND_DOWN, 1'b0, 1'b1, 1'b1));        // inductor at zero
        add_tick(panel_keys(RLY_CAP_UP, 1'b0, 1'b0, 1'b1));          // too early to repeat
        add_tick(panel_keys(RLY_NONE, 1'b0, 1'b1, 1'b0));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_CAP_UP, 1'b0, 1'b1, 1'b1));          // blink carried over
        add_tick(panel_keys(RLY_NONE, 1'b0, 1'b0, 1'b0));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b0, 1'b1));
        add_tick(panel_keys(RLY_ALL, 1'b1, 1'b1, 1'b1));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));
        wait_drained();

        // narrow windows so limits are hit often
        write_limits(8'd6, 8'd2, 8'd4, 8'd1);
        queue_sessions(120);
        wait_drained();

        // minimum above maximum, then counts outside the window
        snd_idle_pct = 84;
        rcv_idle_pct = 29;
        write_limits(8'd0, 8'd255, 8'd255, 8'd0);
        queue_sessions(60);
        wait_drained();
        write_limits(8'd200, 8'd100, 8'd3, 8'd3);
        queue_sessions(60);
        wait_drained();

        // full range, one long hold that steps again after the slow repeat gap
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_limits(8'd255, 8'd0, 8'd255, 8'd0);
        add_tick(panel_keys(RLY_CAP_UP | RLY_IND_DOWN, 1'b0, 1'b1, 1'b1));
        repeat (220) add_tick(panel_keys(RLY_CAP_UP | RLY_IND_DOWN, 1'($urandom),
                                         1'($urandom), 1'($urandom)));
        add_tick(panel_keys(RLY_NONE, 1'b1, 1'b1, 1'b1));
        queue_sessions(40);

        // long receiver hold-offs while beats keep coming
        mark = ticks_taken;
        while (ticks_taken < mark + 100) @(posedge i_clk);
        hold_left = 60;
        while (ticks_taken < mark + 200) @(posedge i_clk);
        hold_left = 90;
        wait_drained();

        repeat (8) @(posedge i_clk);
        $display("covered %0d ticks with %0d session ends and %0d relay writes",
                 ticks_taken, n_ends, n_writes);
        $display("%0d ticks with a blinking bar, step count reached %0d",
                 n_blink, peak_steps);
        if (mismatches == 0 && frame_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### relay_step_keypad_controller.f
sv/rsk_pkg.sv
sv/rsk_step.sv
sv/relay_step_keypad_controller.sv
bench/tb_relay_step_keypad_controller.sv
